>>> design/gscs_pkg.sv
// types and constants for the gamepad stick calibrate/scale block
// no dependencies; used by gscs_if.sv and gamepad_stick_calibrate_scale.sv
package gscs_pkg;

  localparam int AXIS_W   = 12;
  localparam int AXES     = 4;
  localparam int COUNT_W  = 4;

  localparam logic       OP_REPORT = 1'b0;
  localparam logic       OP_CLEAR  = 1'b1;
  localparam logic [7:0] ACCEPTED_ID = 8'h09;
  localparam logic [6:0] MIN_LENGTH  = 7'd12;
  localparam logic [COUNT_W-1:0] SAMPLES_RESET = 4'd4;

  // scale is floor(|d| * 127 / 1600), done as a reciprocal multiply
  localparam int AXIS_GAIN   = 127;
  localparam int AXIS_RANGE  = 1600;
  localparam int SCALE_SHIFT = 24;
  localparam int RECIP_W     = 21;
  localparam int Q_W         = 9;
  localparam longint unsigned SCALE_RECIP_FULL =
    ((longint'(AXIS_GAIN) << SCALE_SHIFT) + longint'(AXIS_RANGE) - 1) / longint'(AXIS_RANGE);
  localparam logic [RECIP_W-1:0] SCALE_RECIP = RECIP_W'(SCALE_RECIP_FULL);
  localparam logic [Q_W-1:0] AXIS_MID     = 9'd128;
  localparam logic [Q_W-1:0] AXIS_POS_MAX = 9'd127;

  typedef logic [AXES-1:0][AXIS_W-1:0] axes_t;

  typedef struct packed {
    logic       op;
    logic [2:0] device_index;
    logic [1:0] hid_instance;
    logic [7:0] rpt_id;
    logic [6:0] report_length;
    logic [7:0] left_byte0;
    logic [7:0] left_byte1;
    logic [7:0] left_byte2;
    logic [7:0] right_byte0;
    logic [7:0] right_byte1;
    logic [7:0] right_byte2;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_device;
    logic [1:0] out_instance;
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] right_x;
    logic [7:0] right_y;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    axes_t              centre;
  } slot_state_t;

endpackage

>>> design/gscs_if.sv
// valid/ready channel interfaces for the stick calibrate/scale block
// depends on gscs_pkg for the payload types
interface gscs_in_if;
  logic                 valid;
  logic                 ready;
  gscs_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gscs_out_if;
  logic                 valid;
  logic                 ready;
  gscs_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gscs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gscs_pkg::COUNT_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/gamepad_stick_calibrate_scale.sv
// flow: an accepted item is registered in stage a with its slot state, processed there
//   once the result register can take it, and its result is loaded into that register
// throughput: one item per cycle unless outp stalls, bounded by the single result register
// reset: sync active-high; then a clearing pass over all DEVICE_SLOTS*INSTANCES_PER_DEVICE
//   slots zeroes the slot state memory, items wait, config writes are taken throughout
// depends on gscs_pkg and the interfaces in gscs_if.sv
module gamepad_stick_calibrate_scale #(
  parameter int DEVICE_SLOTS         = 8,
  parameter int INSTANCES_PER_DEVICE = 4
) (
  input  logic        clk,
  input  logic        rst,
  gscs_in_if.sink     inp,
  gscs_out_if.source  outp,
  gscs_cfg_if.sink    cfg
);

  localparam int SLOT_COUNT = DEVICE_SLOTS * INSTANCES_PER_DEVICE;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // unpack four 12-bit axes from the six packed bytes
  function automatic gscs_pkg::axes_t unpack_axes(input gscs_pkg::in_item_t it);
    gscs_pkg::axes_t ax;
    ax[0] = {it.left_byte1[3:0], it.left_byte0};
    ax[1] = {it.left_byte2, it.left_byte1[7:4]};
    ax[2] = {it.right_byte1[3:0], it.right_byte0};
    ax[3] = {it.right_byte2, it.right_byte1[7:4]};
    return ax;
  endfunction

  // (x - c) * 127 / 1600 toward zero, clamped to -128..127, offset by 128
  function automatic logic [7:0] scale_axis(input logic [gscs_pkg::AXIS_W-1:0] x,
                                            input logic [gscs_pkg::AXIS_W-1:0] c);
    logic                                             neg;
    logic [gscs_pkg::AXIS_W-1:0]                      mag;
    logic [gscs_pkg::AXIS_W+gscs_pkg::RECIP_W-1:0]    prod;
    logic [gscs_pkg::Q_W-1:0]                         q;
    logic [7:0]                                       res;
    neg  = (x < c);
    mag  = neg ? (c - x) : (x - c);
    prod = (gscs_pkg::AXIS_W+gscs_pkg::RECIP_W)'(mag) *
           (gscs_pkg::AXIS_W+gscs_pkg::RECIP_W)'(gscs_pkg::SCALE_RECIP);
    q    = prod[gscs_pkg::SCALE_SHIFT +: gscs_pkg::Q_W];
    if (neg) begin
      res = (q >= gscs_pkg::AXIS_MID) ? 8'd0 : 8'(gscs_pkg::AXIS_MID - q);
    end else begin
      res = (q >= gscs_pkg::AXIS_POS_MAX) ? 8'd255 : 8'(gscs_pkg::AXIS_MID + q);
    end
    return res;
  endfunction

  // calibration sample count register
  logic [gscs_pkg::COUNT_W-1:0] samples;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples <= gscs_pkg::SAMPLES_RESET;
    end else if (cfg.valid && cfg.ready) begin
      samples <= cfg.data;
    end
  end

  // clearing pass over the slot state memory after reset
  logic              clr_busy;
  logic [SLOT_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == SLOT_W'(SLOT_COUNT - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // input side: slot index and range check
  logic [31:0]       slot_wide;
  logic [SLOT_W-1:0] in_slot;
  logic              in_range;
  logic              in_fire;

  assign slot_wide = 32'(inp.data.device_index) * 32'(INSTANCES_PER_DEVICE) +
                     32'(inp.data.hid_instance);
  assign in_slot   = slot_wide[SLOT_W-1:0];
  assign in_range  = (32'(inp.data.device_index) < 32'(DEVICE_SLOTS)) &&
                     (32'(inp.data.hid_instance) < 32'(INSTANCES_PER_DEVICE));

  // stage a holds the accepted item next to the slot state read for it
  logic                  a_valid;
  gscs_pkg::in_item_t    a_item;
  logic [SLOT_W-1:0]     a_slot;
  logic                  a_in_range;
  gscs_pkg::slot_state_t rd_state;
  logic                  a_commit;

  // result register
  logic                  out_valid;
  gscs_pkg::out_item_t   out_data;

  assign a_commit  = a_valid && (!out_valid || outp.ready);
  assign inp.ready = !clr_busy && (!a_valid || a_commit);
  assign in_fire   = inp.valid && inp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_commit) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item     <= inp.data;
      a_slot     <= in_slot;
      a_in_range <= in_range;
    end
  end

  // per-slot state: four centers and the calibration count
  gscs_pkg::slot_state_t state_mem [SLOT_COUNT];
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_addr;
  gscs_pkg::slot_state_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[mem_addr] <= mem_wdata;
    end
  end

  // read with write-through, so back-to-back items on one slot see the update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (mem_we && (mem_addr == in_slot)) begin
        rd_state <= mem_wdata;
      end else begin
        rd_state <= state_mem[in_slot];
      end
    end
  end

  // processing of the item in stage a
  gscs_pkg::axes_t       axes;
  gscs_pkg::slot_state_t upd_state;
  logic                  st_write;
  logic                  produce;
  logic                  is_report;
  logic                  calibrating;
  gscs_pkg::out_item_t   res;

  assign axes        = unpack_axes(a_item);
  assign is_report   = (a_item.report_length >= gscs_pkg::MIN_LENGTH) &&
                       (a_item.rpt_id == gscs_pkg::ACCEPTED_ID);
  assign calibrating = (rd_state.count < samples);

  always_comb begin
    upd_state = rd_state;
    st_write  = 1'b0;
    produce   = 1'b0;
    if (a_in_range) begin
      if (a_item.op == gscs_pkg::OP_CLEAR) begin
        // mount/unmount: restart calibration, centers kept
        upd_state.count = '0;
        st_write        = 1'b1;
      end else if (is_report) begin
        if (calibrating) begin
          for (int i = 0; i < gscs_pkg::AXES; i++) begin
            if (rd_state.count == '0) begin
              upd_state.centre[i] = axes[i];
            end else begin
              upd_state.centre[i] = gscs_pkg::AXIS_W'(
                ({1'b0, rd_state.centre[i]} + {1'b0, axes[i]}) >> 1);
            end
          end
          upd_state.count = rd_state.count + 1'b1;
          st_write        = 1'b1;
        end else begin
          produce = 1'b1;
        end
      end
    end
  end

  // y axes inverted: 255 - v is the bitwise complement
  always_comb begin
    res.out_device   = a_item.device_index;
    res.out_instance = a_item.hid_instance;
    res.left_x       = scale_axis(axes[0], rd_state.centre[0]);
    res.left_y       = ~scale_axis(axes[1], rd_state.centre[1]);
    res.right_x      = scale_axis(axes[2], rd_state.centre[2]);
    res.right_y      = ~scale_axis(axes[3], rd_state.centre[3]);
  end

  // memory write: clearing pass first, then state updates from stage a
  assign mem_we    = clr_busy || (a_commit && st_write);
  assign mem_addr  = clr_busy ? clr_addr : a_slot;
  assign mem_wdata = clr_busy ? '0 : upd_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_commit) begin
      out_valid <= produce;
    end else if (outp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_commit && produce) begin
      out_data <= res;
    end
  end

  assign outp.valid = out_valid;
  assign outp.data  = out_data;

`ifndef SYNTHESIS
  // no item can sit in stage a while the memory is being cleared
  assert property (@(posedge clk) disable iff (rst) clr_busy |-> !a_valid)
    else $error("item in stage a during clearing pass");

  // an accepted item always lands in stage a
  assert property (@(posedge clk) disable iff (rst) in_fire |=> a_valid)
    else $error("accepted item lost before stage a");

  // a stalled stage a keeps its item and slot
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_commit) |=> (a_valid && $stable(a_slot) && $stable(a_item)))
    else $error("stage a changed while stalled");

  // a calibration update never takes the count past the sample register
  assert property (@(posedge clk) disable iff (rst)
    (a_commit && st_write && (a_item.op == gscs_pkg::OP_REPORT)) |->
      (upd_state.count <= samples))
    else $error("calibration count overran sample setting");
`endif

endmodule

>>> sim/testbench.sv
// testbench for gamepad_stick_calibrate_scale: directed and random report items on the
// input channel, results checked against a bench model of slot calibration and axis scaling
// depends on gscs_pkg, the channel interfaces in gscs_if.sv and the block itself
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEVICE_SLOTS         = 8;
  localparam int INSTANCES_PER_DEVICE = 4;
  localparam int SLOT_COUNT           = DEVICE_SLOTS * INSTANCES_PER_DEVICE;
  // longest stretch with no item moving on any channel before the run is called dead
  localparam int WATCHDOG_LIMIT = 3000;
  // cycles to let a report that gives no result get through the block
  localparam int SETTLE_CYCLES  = 8;
  // long result-side hold, started once this many input items have gone in
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RX_HOLD_AT     = 150;
  localparam int PHASE_ITEMS    = 220;

  logic clk;
  logic rst;

  gscs_in_if  in_bus ();
  gscs_out_if out_bus ();
  gscs_cfg_if cfg_bus ();

  gamepad_stick_calibrate_scale #(
    .DEVICE_SLOTS         (DEVICE_SLOTS),
    .INSTANCES_PER_DEVICE (INSTANCES_PER_DEVICE)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .inp  (in_bus),
    .outp (out_bus),
    .cfg  (cfg_bus)
  );

  // bench copy of the block state: register, per-slot centers and calibration counts
  logic [gscs_pkg::COUNT_W-1:0] samples_setting;
  gscs_pkg::axes_t              centres     [SLOT_COUNT];
  logic [gscs_pkg::COUNT_W-1:0] cal_count   [SLOT_COUNT];
  // centers of a slot hold a real value only once a calibration report has landed
  bit                           centre_set  [SLOT_COUNT];

  gscs_pkg::in_item_t  pending_reports [$];  // items waiting to be offered, head is on the bus
  gscs_pkg::out_item_t expected_sticks [$];  // scaled stick results still owed by the block

  int errors         = 0;
  int items_accepted = 0;
  int quiet_cycles   = 0;
  int rx_hold_left   = 0;
  bit rx_hold_done   = 0;
  bit idle_enable    = 1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one axis: (x - center) * 127 / 1600 toward zero, clamped to a signed byte, offset by 128
  function automatic logic [7:0] scale_axis(logic [gscs_pkg::AXIS_W-1:0] x,
                                            logic [gscs_pkg::AXIS_W-1:0] c);
    int diff;
    int s;
    diff = int'(x) - int'(c);
    s = (diff * gscs_pkg::AXIS_GAIN) / gscs_pkg::AXIS_RANGE;
    if (s < -128) s = -128;
    if (s > 127) s = 127;
    return 8'(s + 128);
  endfunction

  // apply one accepted input item to the bench state, queue its result if it gives one
  function automatic void calibrate_and_scale(gscs_pkg::in_item_t it);
    int slot;
    gscs_pkg::axes_t ax;
    logic [gscs_pkg::AXIS_W:0] sum;
    gscs_pkg::out_item_t res;
    slot = int'(it.device_index) * INSTANCES_PER_DEVICE + int'(it.hid_instance);
    // mount/unmount: calibration restarts, centers stay
    if (it.op == gscs_pkg::OP_CLEAR) begin
      cal_count[slot] = '0;
      return;
    end
    // short report or foreign id: nothing happens
    if (it.report_length < gscs_pkg::MIN_LENGTH || it.rpt_id != gscs_pkg::ACCEPTED_ID) return;
    // 12-bit axes packed as x low byte, shared nibble byte, y high byte
    ax[0] = {it.left_byte1[3:0], it.left_byte0};
    ax[1] = {it.left_byte2, it.left_byte1[7:4]};
    ax[2] = {it.right_byte1[3:0], it.right_byte0};
    ax[3] = {it.right_byte2, it.right_byte1[7:4]};
    if (cal_count[slot] < samples_setting) begin
      // first sample sets the center, later ones average it in, rounding down
      for (int i = 0; i < gscs_pkg::AXES; i++) begin
        sum = {1'b0, centres[slot][i]} + {1'b0, ax[i]};
        centres[slot][i] = (cal_count[slot] == 0) ? ax[i] : sum[gscs_pkg::AXIS_W:1];
      end
      cal_count[slot] = cal_count[slot] + 1'b1;
      centre_set[slot] = 1;
      return;
    end
    res.out_device   = it.device_index;
    res.out_instance = it.hid_instance;
    res.left_x       = scale_axis(ax[0], centres[slot][0]);
    res.left_y       = 8'd255 - scale_axis(ax[1], centres[slot][1]);
    res.right_x      = scale_axis(ax[2], centres[slot][2]);
    res.right_y      = 8'd255 - scale_axis(ax[3], centres[slot][3]);
    expected_sticks.push_back(res);
  endfunction

  // a well-formed report for a slot with the four axes packed into the six stick bytes
  function automatic gscs_pkg::in_item_t make_report(int slot,
                                                     logic [gscs_pkg::AXIS_W-1:0] lx, ly,
                                                     rx, ry);
    gscs_pkg::in_item_t it;
    it.op            = gscs_pkg::OP_REPORT;
    it.device_index  = 3'(slot / INSTANCES_PER_DEVICE);
    it.hid_instance  = 2'(slot % INSTANCES_PER_DEVICE);
    it.rpt_id        = gscs_pkg::ACCEPTED_ID;
    it.report_length = gscs_pkg::MIN_LENGTH;
    it.left_byte0    = lx[7:0];
    it.left_byte1    = {ly[3:0], lx[11:8]};
    it.left_byte2    = ly[11:4];
    it.right_byte0   = rx[7:0];
    it.right_byte1   = {ry[3:0], rx[11:8]};
    it.right_byte2   = ry[11:4];
    return it;
  endfunction

  // stick positions: anywhere, pinned to an end stop, or resting near the middle
  function automatic logic [gscs_pkg::AXIS_W-1:0] random_axis();
    case ($urandom_range(3))
      0:       return gscs_pkg::AXIS_W'($urandom_range(4095));
      1:       return $urandom_range(1) ? 12'hFFF : 12'h000;
      default: return gscs_pkg::AXIS_W'($urandom_range(2400, 1700));
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // random reports, mostly well-formed and aimed at a few busy slots so that calibration
  // completes, with clears, short reports, foreign ids and junk mixed in
  task automatic random_phase(int count);
    gscs_pkg::in_item_t it;
    int slot;
    int kind;
    int busy_base;
    busy_base = $urandom_range(SLOT_COUNT - 1);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 70) slot = (busy_base + $urandom_range(3)) % SLOT_COUNT;
      else slot = $urandom_range(SLOT_COUNT - 1);
      it = make_report(slot, random_axis(), random_axis(), random_axis(), random_axis());
      kind = $urandom_range(99);
      if (kind < 6) begin
        it.op = gscs_pkg::OP_CLEAR;
        it.report_length = 7'($urandom_range(64));
        it.rpt_id = 8'($urandom_range(255));
      end else if (kind < 10) begin
        it.report_length = 7'($urandom_range(gscs_pkg::MIN_LENGTH - 1));
      end else if (kind < 14) begin
        it.rpt_id = 8'($urandom_range(255));
        if (it.rpt_id == gscs_pkg::ACCEPTED_ID) it.rpt_id = 8'hFF;
      end else if (kind < 17) begin
        it.op = $urandom_range(1) ? gscs_pkg::OP_CLEAR : gscs_pkg::OP_REPORT;
        it.rpt_id = 8'($urandom_range(255));
        it.report_length = 7'($urandom_range(64));
      end else if (kind < 30) begin
        it.report_length = 7'($urandom_range(64, gscs_pkg::MIN_LENGTH));
      end
      // with calibration off, a slot that never got centers must not be scaled
      if (samples_setting == 0 && !centre_set[slot] && it.op == gscs_pkg::OP_REPORT)
        it.rpt_id = gscs_pkg::ACCEPTED_ID + 8'd1;
      pending_reports.push_back(it);
    end
  endtask

  // hold the sender until every item is in and every result is out, then let the block settle
  task automatic wait_until_drained();
    while (pending_reports.size() != 0 || in_bus.valid || expected_sticks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_samples(logic [gscs_pkg::COUNT_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    samples_setting = value;
  endtask

  // input driver: offers the head of the pending queue, holds it while stalled,
  // and hands every accepted item to the bench model
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        calibrate_and_scale(pending_reports.pop_front());
        items_accepted++;
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (pending_reports.size() != 0 && !(idle_enable && $urandom_range(99) < 14)) begin
          in_bus.valid <= 1'b1;
          in_bus.data  <= pending_reports[0];
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each accepted result against the oldest one owed,
  // and drives ready with random gaps plus one long hold so the block backs up
  always @(posedge clk) begin : rx_monitor
    gscs_pkg::out_item_t want;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_sticks.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual %p", $time, out_bus.data);
        end else begin
          want = expected_sticks.pop_front();
          check_field("out_device", int'(want.out_device), int'(out_bus.data.out_device));
          check_field("out_instance", int'(want.out_instance),
                      int'(out_bus.data.out_instance));
          check_field("left_x", int'(want.left_x), int'(out_bus.data.left_x));
          check_field("left_y", int'(want.left_y), int'(out_bus.data.left_y));
          check_field("right_x", int'(want.right_x), int'(out_bus.data.right_x));
          check_field("right_y", int'(want.right_y), int'(out_bus.data.right_y));
        end
      end
      if (!rx_hold_done && items_accepted >= RX_HOLD_AT) begin
        rx_hold_done = 1;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(idle_enable && $urandom_range(99) < 14);
      end
    end
  end

  // watchdog: any channel moving an item resets the count
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    gscs_pkg::in_item_t it;
    rst           = 1'b1;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    samples_setting = gscs_pkg::SAMPLES_RESET;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      centres[s]    = '0;
      cal_count[s]  = '0;
      centre_set[s] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part, register at its reset value of four samples
    // clear on a slot that has never seen a report
    it = make_report(0, 12'h000, 12'h000, 12'h000, 12'h000);
    it.op = gscs_pkg::OP_CLEAR;
    pending_reports.push_back(it);
    // dropped reports on the last slot: foreign id at length 64, one byte short,
    // zero id and zero length, top id at the minimum length
    it = make_report(SLOT_COUNT - 1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    it.rpt_id = gscs_pkg::ACCEPTED_ID - 8'd1;
    it.report_length = 7'd64;
    pending_reports.push_back(it);
    it.rpt_id = gscs_pkg::ACCEPTED_ID;
    it.report_length = gscs_pkg::MIN_LENGTH - 7'd1;
    pending_reports.push_back(it);
    it.rpt_id = 8'h00;
    it.report_length = 7'd0;
    pending_reports.push_back(it);
    it.rpt_id = 8'hFF;
    it.report_length = gscs_pkg::MIN_LENGTH;
    pending_reports.push_back(it);
    // four calibration samples on the last slot, odd sums exercise the rounding down,
    // with slot zero starting its own calibration in between
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h800, 12'h800, 12'h7FF, 12'h001));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h800, 12'h800, 12'h800, 12'h000));
    pending_reports.push_back(make_report(0, 12'h123, 12'hABC, 12'h000, 12'hFFF));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h800, 12'h800, 12'h7FF, 12'hFFF));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h800, 12'h800, 12'h802, 12'h800));
    // calibrated: rest position, both end stops, and the smallest steps either side of
    // center where truncation toward zero matters
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h800, 12'h800, 12'h800, 12'h800));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'hFFF, 12'h000, 12'hFFF, 12'h000));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h000, 12'hFFF, 12'h000, 12'hFFF));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h80C, 12'h7F3, 12'h80D, 12'h7F4));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h7F4, 12'h80D, 12'h7F3, 12'h80C));
    // unmount: calibration starts over from a fresh first sample
    it = make_report(SLOT_COUNT - 1, 12'h000, 12'h000, 12'h000, 12'h000);
    it.op = gscs_pkg::OP_CLEAR;
    pending_reports.push_back(it);
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h100, 12'hE00, 12'h555, 12'hAAA));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h101, 12'hE03, 12'h556, 12'hAA9));
    pending_reports.push_back(make_report(0, 12'h124, 12'hABD, 12'h001, 12'hFFE));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h0FF, 12'hDFF, 12'h557, 12'hAAB));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h103, 12'hE01, 12'h554, 12'hAA8));
    pending_reports.push_back(make_report(SLOT_COUNT - 1, 12'h7FF, 12'h000, 12'hFFF, 12'h800));

    // random traffic at the reset setting; the long result-side hold falls in here
    random_phase(PHASE_ITEMS);
    wait_until_drained();

    // longest calibration
    write_samples(4'd15);
    random_phase(PHASE_ITEMS);
    wait_until_drained();

    // register lowered below counts left part way: those slots start giving results
    write_samples(4'd1);
    random_phase(PHASE_ITEMS);
    wait_until_drained();

    // calibration off, results use whatever centers are stored
    write_samples(4'd0);
    random_phase(PHASE_ITEMS);
    wait_until_drained();

    // back-to-back traffic with no gaps on either side
    write_samples(4'd9);
    idle_enable = 0;
    random_phase(PHASE_ITEMS);
    wait_until_drained();
    idle_enable = 1;

    write_samples(4'd15);
    random_phase(PHASE_ITEMS / 2);
    wait_until_drained();

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> gamepad_stick_calibrate_scale.f
design/gscs_pkg.sv
design/gscs_if.sv
design/gamepad_stick_calibrate_scale.sv
sim/testbench.sv
